@@ rtl/core/isdn_pkg.sv @@
// Shared types, constants and tables for the Ising denoise pixel update block.
// Self-contained; imported by ising_denoise_pixel_update_top.

package isdn_pkg;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_FETCH,
    ST_DRAIN,
    ST_DECIDE,
    ST_FINISH
  } state_t;

  // Operation codes carried on the input tuser
  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_UPDATE = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  // Configuration register indexes
  localparam logic CFG_BETA  = 1'b0;
  localparam logic CFG_GAMMA = 1'b1;

  localparam logic signed [15:0] BETA_RESET  = 16'sd1638;
  localparam logic signed [15:0] GAMMA_RESET = 16'sd3553;

  localparam int DEFAULT_IMAGE_SIZE = 256;
  // Row and column are 8 bits wide, so no more than 256 of them are addressable
  localparam int MAX_EDGE = 256;

  // Port widths
  localparam int IN_DATA_W  = 24;  // row, col, pixel_in, thresh_tenths, padded
  localparam int IN_USER_W  = 2;   // op
  localparam int OUT_DATA_W = 8;   // pixel_out, flipped, padded
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // Energy accumulator: nine terms of up to 2^16 each, plus sign
  localparam int EW = 21;

  // Fetch sequence: centre first, then the eight neighbours
  localparam logic [3:0] NBR_CENTRE = 4'd0;
  localparam logic [3:0] NBR_LAST   = 4'd8;

  localparam logic [3:0] THR_ZERO = 4'd0;
  localparam logic [3:0] THR_TEN  = 4'd10;

  // Row offset of fetch step k, two's complement
  function automatic logic [1:0] nbr_dr(input logic [3:0] k);
    logic [1:0] d;
    d = 2'b00;
    case (k)
      4'd1, 4'd2, 4'd3: d = 2'b11;
      4'd6, 4'd7, 4'd8: d = 2'b01;
      default:          d = 2'b00;
    endcase
    return d;
  endfunction

  // Column offset of fetch step k, two's complement
  function automatic logic [1:0] nbr_dc(input logic [3:0] k);
    logic [1:0] d;
    d = 2'b00;
    case (k)
      4'd1, 4'd4, 4'd6: d = 2'b11;
      4'd3, 4'd5, 4'd8: d = 2'b01;
      default:          d = 2'b00;
    endcase
    return d;
  endfunction

  // floor(4096 * ln(t/10)) for t = 1..9
  function automatic logic signed [EW-1:0] ln_tenths(input logic [3:0] t);
    logic signed [EW-1:0] v;
    v = '0;
    case (t)
      4'd1:    v = -21'sd9432;
      4'd2:    v = -21'sd6593;
      4'd3:    v = -21'sd4932;
      4'd4:    v = -21'sd3754;
      4'd5:    v = -21'sd2840;
      4'd6:    v = -21'sd2093;
      4'd7:    v = -21'sd1461;
      4'd8:    v = -21'sd914;
      4'd9:    v = -21'sd432;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/core/ising_denoise_pixel_update_top.sv @@
// Ising-model binary image denoising: pixel stores and Metropolis update sequencer.
// Depends on isdn_pkg (states, op codes, neighbour offsets, ln table).
//
// Channel    | dir | handshake          | payload
// -----------+-----+--------------------+------------------------------------------
// s (items)  | in  | s_tvalid/s_tready  | s_tuser: op; s_tdata: row, col, pixel_in,
//            |     |                    |   thresh_tenths
// m (result) | out | m_tvalid/m_tready  | m_tdata: pixel_out, flipped
// cfg        | in  | cfg_wr_en          | cfg_index, cfg_data (beta, gamma)
//
// Order: one item is in work at a time. A load goes from WRITE to FINISH; a read
// and an update go FETCH, DRAIN, DECIDE, FINISH, and an update's nine pixel fetches share
// the single read port of the pixel stores and the one add/subtract unit that builds
// the energy. An item outside the image or with an unused op goes straight to its result.
// Reset clears the sequencer, the output valid and the weights; the pixel
// stores hold whatever they held and need no clearing pass.
// A stalled result sits in the output register; the next item is taken
// meanwhile and only its final transfer into the output register waits.

module ising_denoise_pixel_update_top #(
  parameter int IMAGE_SIZE = isdn_pkg::DEFAULT_IMAGE_SIZE
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // [7:0] row, [15:8] col, [16] pixel_in, [20:17] thresh_tenths, [23:21] zero
  input  logic [isdn_pkg::IN_DATA_W-1:0]  s_tdata,
  // [1:0] op
  input  logic [isdn_pkg::IN_USER_W-1:0]  s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [0] pixel_out, [1] flipped, [7:2] zero
  output logic [isdn_pkg::OUT_DATA_W-1:0] m_tdata,
  input  logic                            cfg_wr_en,
  input  logic [isdn_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [isdn_pkg::CFG_DATA_W-1:0] cfg_data
);
  import isdn_pkg::*;

  // Addressable edge, and a power-of-two row stride for the stores
  localparam int EDGE  = (IMAGE_SIZE < MAX_EDGE) ? IMAGE_SIZE : MAX_EDGE;
  localparam int CW    = $clog2(EDGE);
  localparam int AW    = 2 * CW;
  localparam int DEPTH = 1 << AW;

  state_t state, state_next;

  // Item registers
  logic [1:0] op_q;
  logic [7:0] row_q, col_q;
  logic       pin_q;
  logic [3:0] thr_q;

  logic signed [15:0] beta, gamma;

  // Fetch sequencer
  logic [3:0] k, k_next;
  logic [3:0] last_k;

  // Read pipeline tags
  logic       rd_valid;
  logic [3:0] rd_k;
  logic       rd_in;
  logic       rd_cur, rd_noisy;

  // Centre spin and energy
  logic                 z_c;
  logic signed [EW-1:0] acc;
  logic                 res_pix, res_flip;

  // Output register
  logic out_pix, out_flip;

  // Pixel stores
  logic noisy_mem [DEPTH];
  logic cur_mem   [DEPTH];

  // Handshake and control strobes
  logic in_xfer, in_ok, fetch_en, load_we, flip_we, fin_load, flip_now;

  logic [7:0]  in_row, in_col;
  logic [1:0]  dr_k, dc_k;
  logic [10:0] nr, nc;
  logic        nbr_in;
  logic [AW-1:0] rd_addr, wr_addr;

  // Shared add/subtract unit
  logic signed [EW-1:0] g2, b2, add_base, add_mag, acc_sum;
  logic                 add_sub;

  assign in_row  = s_tdata[7:0];
  assign in_col  = s_tdata[15:8];
  assign in_xfer = s_tvalid && s_tready;
  // Centre must be inside the image and the op must mean something
  assign in_ok   = ({1'b0, in_row} < 9'(EDGE)) && ({1'b0, in_col} < 9'(EDGE)) &&
                   ((s_tuser == OP_LOAD) || (s_tuser == OP_UPDATE) ||
                    (s_tuser == OP_READ));

  assign last_k = (op_q == OP_UPDATE) ? NBR_LAST : NBR_CENTRE;

  // Neighbour position for the current fetch step; -1 appears as bit 10 set
  assign dr_k    = nbr_dr(k);
  assign dc_k    = nbr_dc(k);
  assign nr      = {3'b000, row_q} + {{9{dr_k[1]}}, dr_k};
  assign nc      = {3'b000, col_q} + {{9{dc_k[1]}}, dc_k};
  assign nbr_in  = !nr[10] && (nr < 11'(EDGE)) && !nc[10] && (nc < 11'(EDGE));
  assign rd_addr = {nr[CW-1:0], nc[CW-1:0]};
  assign wr_addr = {row_q[CW-1:0], col_q[CW-1:0]};

  // Metropolis decision: flip when ln(t/10) < E; t of zero always flips, t of ten or more never
  always_comb begin
    priority if (thr_q == THR_ZERO) begin
      flip_now = 1'b1;
    end else if (thr_q >= THR_TEN) begin
      flip_now = 1'b0;
    end else begin
      flip_now = acc > ln_tenths(thr_q);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    k_next     = k;
    s_tready   = 1'b0;
    fetch_en   = 1'b0;
    load_we    = 1'b0;
    flip_we    = 1'b0;
    fin_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        k_next   = NBR_CENTRE;
        if (s_tvalid) begin
          if (!in_ok) begin
            state_next = ST_FINISH;
          end else if (s_tuser == OP_LOAD) begin
            state_next = ST_WRITE;
          end else begin
            state_next = ST_FETCH;
          end
        end
      end
      ST_WRITE: begin
        load_we    = 1'b1;
        state_next = ST_FINISH;
      end
      ST_FETCH: begin
        fetch_en = 1'b1;
        k_next   = k + 4'd1;
        if (k == last_k) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // let the last fetched pixel reach the accumulator
        state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        flip_we    = (op_q == OP_UPDATE) && flip_now;
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        // hold the result until the output register is free
        if (!m_tvalid || m_tready) begin
          fin_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Pixel stores: one write and one read address per cycle, read data registered
  always_ff @(posedge clk) begin
    if (load_we) begin
      noisy_mem[wr_addr] <= pin_q;
      cur_mem[wr_addr]   <= pin_q;
    end else if (flip_we) begin
      cur_mem[wr_addr] <= ~z_c;
    end
    rd_cur   <= cur_mem[rd_addr];
    rd_noisy <= noisy_mem[rd_addr];
  end

  // Energy term for the pixel just read:
  //   centre:    -2*gamma*x*z, subtract when x and z agree
  //   neighbour: -2*beta*z*s, subtract when s agrees with z, nothing outside
  assign g2 = {{(EW-17){gamma[15]}}, gamma, 1'b0};
  assign b2 = {{(EW-17){beta[15]}}, beta, 1'b0};

  always_comb begin
    if (rd_k == NBR_CENTRE) begin
      add_base = '0;
      add_mag  = g2;
      add_sub  = (rd_noisy == rd_cur);
    end else begin
      add_base = acc;
      add_mag  = rd_in ? b2 : '0;
      add_sub  = (rd_cur == z_c);
    end
  end

  assign acc_sum = add_sub ? (add_base - add_mag) : (add_base + add_mag);

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      k        <= NBR_CENTRE;
      rd_valid <= 1'b0;
      m_tvalid <= 1'b0;
      beta     <= BETA_RESET;
      gamma    <= GAMMA_RESET;
    end else begin
      k        <= k_next;
      rd_valid <= fetch_en;
      if (fin_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_BETA:  beta  <= cfg_data;
          CFG_GAMMA: gamma <= cfg_data;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_q     <= s_tuser;
      row_q    <= in_row;
      col_q    <= in_col;
      pin_q    <= s_tdata[16];
      thr_q    <= s_tdata[20:17];
      res_pix  <= 1'b0;
      res_flip <= 1'b0;
    end else if (state == ST_WRITE) begin
      res_pix <= pin_q;
    end else if (state == ST_DECIDE) begin
      res_pix  <= z_c ^ flip_we;
      res_flip <= flip_we;
    end
    rd_k  <= k;
    rd_in <= nbr_in;
    if (rd_valid) begin
      acc <= acc_sum;
      if (rd_k == NBR_CENTRE) begin
        z_c <= rd_cur;
      end
    end
    if (fin_load) begin
      out_pix  <= res_pix;
      out_flip <= res_flip;
    end
  end

  assign m_tdata = {6'b000000, out_flip, out_pix};

  // A fresh item locks the input until its result is loaded into the output register
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> !s_tready)
    else $error("input accepted while an item is in work");

  // Pixel reads only come back while fetching or draining
  a_read_in_fetch: assert property (@(posedge clk) disable iff (rst)
    rd_valid |-> (state == ST_FETCH) || (state == ST_DRAIN))
    else $error("pixel read outside the fetch sequence");

  // Only an update can flip
  a_flip_update: assert property (@(posedge clk) disable iff (rst)
    flip_we |-> (op_q == OP_UPDATE))
    else $error("flip write for a non-update item");

  // Finishing always presents a result next cycle
  a_finish_valid: assert property (@(posedge clk) disable iff (rst)
    fin_load |=> m_tvalid && (m_tdata[1] == $past(res_flip)))
    else $error("finished result not presented");

  // A flipped pixel has changed its centre spin
  a_flip_value: assert property (@(posedge clk) disable iff (rst)
    fin_load && res_flip |-> (res_pix != z_c))
    else $error("flip reported without a spin change");

endmodule
